// ===== hdl/mme_pkg.sv =====
// Package of shared constants and control types for the modular exponentiation block.
`timescale 1ns / 1ps

package mme_pkg;

    // Datapath width in bits; base, exponent, modulus and result all use it.
    localparam int WIDTH = 32;
    // Bits needed to select one bit of a WIDTH-bit operand.
    localparam int IDX_W = $clog2(WIDTH);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_DBL,
        ST_RED_ADD,
        ST_RED_COMMIT,
        ST_CHECK,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_BIT_COMMIT
    } mme_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;        // capture a new input word
        logic             clr_prod;    // clear both product accumulators
        logic             dbl;         // double step of both multipliers
        logic             add;         // conditional add step of both multipliers
        logic             red_commit;  // reduced base replaces the input base
        logic             bit_commit;  // close one exponent bit
        logic             out_load;    // move the result into the output register
        logic [IDX_W-1:0] idx;         // multiplier bit in use
    } mme_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_zero;  // no set exponent bits remain
    } mme_sts_t;

endpackage

// ===== hdl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: controller, datapath and ports.
`timescale 1ns / 1ps

// The block raises a base to an exponent modulo a configured modulus, using
// right-to-left square-and-multiply with bit-serial modular multipliers.
// Input words arrive on the s_ channel (base and exponent in s_tdata) and one
// result word per input leaves on the m_ channel. The modulus is written
// through cfg_we / cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce. A value of zero acts as
// two to the 32nd power. The work for a word grows with the bit length of
// the exponent (0 to 32). Each modular multiplication does a double and an
// add per multiplier bit, one at a time through the single add-and-compare
// in each multiplier unit; the squaring and the conditional product run side
// by side in two units. One word is worked on at a time; the block returns to
// idle as the result enters the output register, and takes the next word from
// there.
// A finished result waits in the output register, so a new word can be
// accepted and processed while the receiver stalls; the block holds only at
// the end of that next word if the earlier result has still not been taken.
// Reset (aresetn low at a clock edge) empties the block and sets the modulus
// to one.
module modular_exponentiation
    import mme_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration: modulus register.
    input  logic                   cfg_we,
    input  logic [WIDTH-1:0]       cfg_wdata,
    // Input channel.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*WIDTH-1:0]     s_tdata,   // [31:0] base, [63:32] exponent
    // Result channel.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [WIDTH-1:0]       m_tdata    // [31:0] result
);

    mme_cmd_t cmd;
    mme_sts_t sts;

    // The controller owns the handshakes and the bit index; the datapath only
    // follows its commands.
    mme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mme_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_base     (s_tdata[WIDTH-1:0]),
        .in_exponent (s_tdata[2*WIDTH-1:WIDTH]),
        .cmd         (cmd),
        .sts         (sts),
        .out_result  (m_tdata)
    );

endmodule

// ===== hdl/mme_mulmod.sv =====
// Bit-serial modular multiplier: one modular double or one modular add per cycle, as commanded.
`timescale 1ns / 1ps

module mme_mulmod
    import mme_pkg::*;
(
    input  logic             aclk,
    input  logic             clr,
    input  logic             dbl,
    input  logic             add,
    input  logic             mult_bit,
    input  logic [WIDTH-1:0] addend,
    input  logic [WIDTH:0]   mod_ext,
    output logic [WIDTH-1:0] prod
);

    logic [WIDTH-1:0] prod_reg;
    logic [WIDTH-1:0] prod_next;
    logic [WIDTH-1:0] operand;
    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   red;

    // The product is doubled, or the addend is added when the multiplier bit is set.
    // A single subtraction of the modulus brings the sum back into range.
    always_comb begin
        operand = dbl ? prod_reg : (mult_bit ? addend : '0);
        sum     = {1'b0, prod_reg} + {1'b0, operand};
        red     = (sum >= mod_ext) ? (sum - mod_ext) : sum;
        if (clr) begin
            prod_next = '0;
        end else if (dbl || add) begin
            prod_next = red[WIDTH-1:0];
        end else begin
            prod_next = prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/mme_datapath.sv =====
// Datapath: modulus, base, exponent and result registers with two modular multipliers.
`timescale 1ns / 1ps

module mme_datapath
    import mme_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [WIDTH-1:0] cfg_wdata,
    input  logic [WIDTH-1:0] in_base,
    input  logic [WIDTH-1:0] in_exponent,
    input  mme_cmd_t         cmd,
    output mme_sts_t         sts,
    output logic [WIDTH-1:0] out_result
);

    logic [WIDTH:0]   mod_ext_reg;
    logic [WIDTH:0]   mod_ext_next;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] base_next;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] exp_next;
    logic [WIDTH-1:0] res_reg;
    logic [WIDTH-1:0] res_next;
    logic [WIDTH-1:0] out_reg;
    logic [WIDTH-1:0] out_next;
    logic [WIDTH-1:0] prod_a;
    logic [WIDTH-1:0] prod_b;
    logic             mult_bit;

    // A modulus of zero stands for two to the WIDTH, so it is kept one bit wider.
    always_comb begin
        mod_ext_next = mod_ext_reg;
        if (cfg_we) begin
            mod_ext_next = {(cfg_wdata == '0), cfg_wdata};
        end
    end

    always_comb begin
        base_next = base_reg;
        exp_next  = exp_reg;
        res_next  = res_reg;
        out_next  = out_reg;
        if (cmd.load) begin
            base_next = in_base;
            exp_next  = in_exponent;
            res_next  = WIDTH'(1);
        end
        if (cmd.red_commit) begin
            base_next = prod_a;
        end
        if (cmd.bit_commit) begin
            if (exp_reg[0]) begin
                res_next = prod_a;
            end
            base_next = prod_b;
            exp_next  = exp_reg >> 1;
        end
        if (cmd.out_load) begin
            out_next = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_ext_reg <= (WIDTH+1)'(1);
        end else begin
            mod_ext_reg <= mod_ext_next;
        end
        base_reg <= base_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign mult_bit = base_reg[cmd.idx];

    // Unit A forms result times base (and, with the result at one, reduces the base).
    mme_mulmod u_mul_a (
        .aclk     (aclk),
        .clr      (cmd.clr_prod),
        .dbl      (cmd.dbl),
        .add      (cmd.add),
        .mult_bit (mult_bit),
        .addend   (res_reg),
        .mod_ext  (mod_ext_reg),
        .prod     (prod_a)
    );

    // Unit B squares the base.
    mme_mulmod u_mul_b (
        .aclk     (aclk),
        .clr      (cmd.clr_prod),
        .dbl      (cmd.dbl),
        .add      (cmd.add),
        .mult_bit (mult_bit),
        .addend   (base_reg),
        .mod_ext  (mod_ext_reg),
        .prod     (prod_b)
    );

    assign sts.exp_zero = (exp_reg == '0);
    assign out_result   = out_reg;

    a_exp_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.bit_commit && !cmd.load |=> exp_reg == ($past(exp_reg) >> 1))
        else $error("exponent not shifted on bit commit");

    a_res_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> res_reg == WIDTH'(1))
        else $error("result not set to one on load");

endmodule

// ===== hdl/mme_ctrl.sv =====
// Controller state machine sequencing reduction, multiplications and output.
`timescale 1ns / 1ps

module mme_ctrl
    import mme_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  mme_sts_t sts,
    output mme_cmd_t cmd
);

    mme_state_t       state_reg;
    mme_state_t       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= IDX_MAX;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        s_tready   = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load     = 1'b1;
                    cmd.clr_prod = 1'b1;
                    idx_next     = IDX_MAX;
                    state_next   = ST_RED_DBL;
                end
            end
            ST_RED_DBL: begin
                cmd.dbl    = 1'b1;
                state_next = ST_RED_ADD;
            end
            ST_RED_ADD: begin
                cmd.add = 1'b1;
                if (idx_reg == '0) begin
                    state_next = ST_RED_COMMIT;
                end else begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_RED_DBL;
                end
            end
            ST_RED_COMMIT: begin
                cmd.red_commit = 1'b1;
                cmd.clr_prod   = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK: begin
                idx_next = IDX_MAX;
                if (!sts.exp_zero) begin
                    state_next = ST_MUL_DBL;
                end else if (!out_valid_reg || m_tready) begin
                    finish       = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MUL_DBL: begin
                cmd.dbl    = 1'b1;
                state_next = ST_MUL_ADD;
            end
            ST_MUL_ADD: begin
                cmd.add = 1'b1;
                if (idx_reg == '0) begin
                    state_next = ST_BIT_COMMIT;
                end else begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_MUL_DBL;
                end
            end
            ST_BIT_COMMIT: begin
                cmd.bit_commit = 1'b1;
                cmd.clr_prod   = 1'b1;
                state_next     = ST_CHECK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (finish) begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while still pending");

    a_step_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.dbl && cmd.add) && !(cmd.load && (cmd.dbl || cmd.add || cmd.bit_commit)))
        else $error("conflicting datapath commands");

    a_mul_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_ADD && idx_reg == '0) |=> state_reg == ST_BIT_COMMIT)
        else $error("multiplication did not end after the last bit");

    a_load_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (idx_reg == IDX_MAX && state_reg == ST_RED_DBL))
        else $error("bit index not restarted on load");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

// The testbench drives base/exponent words into the s_ channel and checks every
// word that leaves the m_ channel against a behavioural square-and-multiply
// predictor kept here. Expected results wait in a queue in the order in which
// their input words were accepted, and each returned word is compared with the
// oldest one.
//
// The run has two parts. A directed table comes first. It covers the reset
// modulus of one, the extremes of every field, an exponent of zero, and a
// modulus of zero, which the block takes as two to the 32nd power. Where a
// result is obvious, it is typed into the table. Six random phases follow,
// each with its own modulus. Exponent lengths are spread evenly, so that short
// and long runs of the multiplier loop both turn up.
//
// The modulus is only rewritten once the block has returned every word it
// owes. Each input gives exactly one result, so an empty queue means the
// block is idle.
module tb_top
    import mme_pkg::*;
;

    localparam int     CLK_PERIOD  = 10;
    localparam int     NUM_DIR     = 21;
    localparam int     NUM_PHASES  = 6;
    localparam int     PHASE_WORDS = 45;
    // Both sides stop idling while their word count lies in this window.
    localparam int     QUIET_FROM  = 150;
    localparam int     QUIET_TO    = 200;
    // The tail outlasts the longest latency, so it covers one full word.
    localparam int     TAIL_CYCLES = 2200;
    // There are about 300 words of up to the longest latency each, taken several
    // times over.
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef logic [WIDTH-1:0] word_t;

    // One row of the directed table. Where pinned is set, value is the result
    // typed in by hand; otherwise the predictor supplies it.
    typedef struct packed {
        word_t modulus;
        word_t base;
        word_t expo;
        logic  pinned;
        word_t value;
    } dir_row_t;

    typedef struct {
        int    tag;
        word_t value;
    } due_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    word_t              cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [2*WIDTH-1:0] s_tdata   = '0;  // [31:0] base, [63:32] exponent
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    word_t              m_tdata;          // [31:0] result

    // This shadow of the modulus register tracks every write that the
    // testbench makes.
    word_t  modulus_now = 32'd1;
    due_t   results_due[$];
    int     words_sent   = 0;
    int     results_seen = 0;
    int     error_count  = 0;
    longint cycle_count  = 0;

    dir_row_t dir_rows [0:NUM_DIR-1] = '{
        // The reset modulus of one: an exponent of zero still gives one,
        // and anything else gives zero.
        '{32'h0000_0001, 32'h0000_0005, 32'h0000_0000, 1'b1, 32'h0000_0001},
        '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
        // The largest modulus. A base at or above it is reduced first.
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0002, 1'b1, 32'h0000_0001},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        // A modulus of zero: the arithmetic wraps at two to the 32nd power.
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 32'h0000_0001},
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0003, 1'b1, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'h0000_0002, 32'h0000_0020, 1'b1, 32'h0000_0000},
        '{32'h0000_0000, 32'h0000_0002, 32'h0000_001F, 1'b1, 32'h8000_0000},
        '{32'h0000_0000, 32'h0000_0003, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{32'h0000_0000, 32'h0000_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000},
        // The smallest even modulus and a power of two.
        '{32'h0000_0002, 32'h0000_0007, 32'hAAAA_AAAA, 1'b1, 32'h0000_0001},
        '{32'h0000_0002, 32'h0000_0006, 32'h5555_5555, 1'b1, 32'h0000_0000},
        '{32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000},
        // The largest 32-bit prime. By Fermat, 2^(p-1) is one.
        '{32'hFFFF_FFFB, 32'h0000_0002, 32'hFFFF_FFFA, 1'b1, 32'h0000_0001},
        '{32'hFFFF_FFFB, 32'hDEAD_BEEF, 32'h0001_0001, 1'b0, 32'h0000_0000}
    };

    modular_exponentiation u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // (a * b) mod m, where a modulus of zero stands for two to the WIDTH.
    // The full double-width product is formed, so that no bits are lost
    // before the reduction.
    function automatic word_t times_mod(input word_t a, input word_t b, input word_t m);
        logic [2*WIDTH-1:0] prod;
        prod = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
        if (m == '0) begin
            return prod[WIDTH-1:0];
        end
        return word_t'(prod % {{WIDTH{1'b0}}, m});
    endfunction

    // The running product starts at one and is never reduced on its own.
    // An exponent of zero therefore gives one, even for a modulus of one.
    function automatic word_t expmod_predict(input word_t base, input word_t expo,
                                             input word_t m);
        word_t acc;
        word_t sq;
        word_t rest;
        acc  = word_t'(1);
        sq   = (m == '0) ? base : base % m;
        rest = expo;
        while (rest != '0) begin
            if (rest[0]) begin
                acc = times_mod(acc, sq, m);
            end
            sq   = times_mod(sq, sq, m);
            rest = rest >> 1;
        end
        return acc;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic wait_drained();
        while (results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // The modulus may only change while nothing is in flight. The input side
    // is therefore closed first, and every word owed is collected before
    // the write.
    task automatic load_modulus(input word_t value);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        modulus_now = value;
    endtask

    // Offers one word after a random idle spell, and queues its result once
    // the word is accepted. The valid stays high from one word to the next
    // unless an idle spell falls between them, so that no step assigns
    // it twice.
    task automatic send_word(input word_t base, input word_t expo, input logic pinned,
                             input word_t value);
        due_t due;
        while (!(words_sent >= QUIET_FROM && words_sent < QUIET_TO) &&
               $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {expo, base};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        due.tag   = words_sent;
        due.value = pinned ? value : expmod_predict(base, expo, modulus_now);
        results_due.push_back(due);
        words_sent++;
    endtask

    // Result side. Outputs are sampled at the edge itself, before the block's
    // own updates land. The ready for the next cycle is then redrawn.
    always @(posedge aclk) begin
        due_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                flag_error($sformatf("result %h arrived with nothing outstanding", m_tdata));
            end else begin
                due = results_due.pop_front();
                if (m_tdata !== due.value) begin
                    flag_error($sformatf("word %0d: result %h, expected %h",
                                         due.tag, m_tdata, due.value));
                end
            end
            results_seen++;
        end
        m_tready <= (results_seen >= QUIET_FROM && results_seen < QUIET_TO) ||
                    ($urandom_range(99) >= 24);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        dir_row_t row;
        word_t    mod_pick;
        word_t    base;
        word_t    expo;
        int       len;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. The first rows run on the reset value of the modulus.
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.modulus != modulus_now) begin
                load_modulus(row.modulus);
            end
            send_word(row.base, row.expo, row.pinned, row.value);
        end

        // Random part. Each phase has its own modulus. The explicit writes of
        // one, zero and all ones make sure the register sees every extreme
        // through the write port as well.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    mod_pick = word_t'($urandom) | 32'h8000_0000;
                end
                1: begin
                    mod_pick = word_t'($urandom_range(2, 300));
                end
                2: begin
                    mod_pick = word_t'(1);
                end
                3: begin
                    mod_pick = '0;
                end
                4: begin
                    mod_pick = '1;
                end
                default: begin
                    mod_pick = word_t'($urandom_range(3, 32'h00FF_FFFF));
                end
            endcase
            load_modulus(mod_pick);
            repeat (PHASE_WORDS) begin
                // Bases are biased towards zero, all ones and the values
                // around the modulus, where the first reduction is most
                // likely to slip.
                case ($urandom_range(7))
                    0: begin
                        base = '0;
                    end
                    1: begin
                        base = '1;
                    end
                    2: begin
                        base = mod_pick + word_t'($urandom_range(0, 2)) - word_t'(1);
                    end
                    default: begin
                        base = word_t'($urandom);
                    end
                endcase
                // The exponent bit length is spread evenly over 0..WIDTH, with
                // the top bit forced, so that every loop length turns up.
                len = $urandom_range(0, WIDTH);
                if ($urandom_range(9) == 0) begin
                    expo = '1;
                end else if (len == 0) begin
                    expo = '0;
                end else begin
                    expo = word_t'($urandom) >> (WIDTH - len);
                    expo[len-1] = 1'b1;
                end
                send_word(base, expo, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        // Any stray word that follows would still turn up within one full
        // latency.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mme_pkg.sv
hdl/mme_mulmod.sv
hdl/mme_datapath.sv
hdl/mme_ctrl.sv
hdl/modular_exponentiation.sv
tb/tb_top.sv
